// ===== design/rqr_pkg.sv =====
// shared types and constants for the ready queue with remove
// depends on nothing; used by rqr_ctrl, rqr_dpath and the top level

package rqr_pkg;

    // field widths fixed by the interface
    localparam int ACT_W  = 2;
    localparam int TID_W  = 8;
    localparam int STAT_W = 2;

    // operation codes
    localparam logic [ACT_W-1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TEST    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic              load;        // latch the incoming transaction
        logic              enq;         // write key at tail, grow queue
        logic              deq_rd;      // read entry at head
        logic              deq_fin;     // take head entry, shrink queue
        logic              scan_start;  // read at head, scan position to head
        logic              scan_read;   // read entry after scan position
        logic              scan_adv;    // move scan position on by one
        logic              shift_step;  // move one younger entry forward
        logic              rem_fin;     // pull tail back, shrink queue
        logic              set_res;     // capture result status
        logic [STAT_W-1:0] res_status;
        logic              push;        // move result into output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             full;
        logic             empty;
        logic             match;       // read data equals the key
        logic             at_last;     // scan position is the youngest entry
        logic             shift_last;  // scan position is second youngest
        logic             out_free;    // output register can take a result
    } t_stat;

endpackage

// ===== design/rqr_ctrl.sv =====
// controller state machine for the ready queue with remove
// depends on rqr_pkg (t_cmd, t_stat, operation and status codes)

module rqr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rqr_pkg::t_stat i_stat,
    output rqr_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_DEQ    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.act)
                    rqr_pkg::ACT_ENQUEUE: begin
                        o_cmd.set_res = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.res_status = rqr_pkg::ST_FULL;
                        end else begin
                            o_cmd.enq        = 1'b1;
                            o_cmd.res_status = rqr_pkg::ST_DONE;
                        end
                        n_state = S_RESULT;
                    end
                    rqr_pkg::ACT_DEQUEUE: begin
                        if (i_stat.empty) begin
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_status = rqr_pkg::ST_MISS;
                            n_state          = S_RESULT;
                        end else begin
                            o_cmd.deq_rd = 1'b1;
                            n_state      = S_DEQ;
                        end
                    end
                    rqr_pkg::ACT_TEST, rqr_pkg::ACT_REMOVE: begin
                        if (i_stat.empty) begin
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_status = rqr_pkg::ST_MISS;
                            n_state          = S_RESULT;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DEQ: begin
                o_cmd.deq_fin    = 1'b1;
                o_cmd.set_res    = 1'b1;
                o_cmd.res_status = rqr_pkg::ST_DONE;
                n_state          = S_RESULT;
            end
            S_SCAN: begin
                // the read after the scan position always goes out
                o_cmd.scan_read = 1'b1;
                priority if (i_stat.match) begin
                    if (i_stat.act == rqr_pkg::ACT_TEST) begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = rqr_pkg::ST_DONE;
                        n_state          = S_RESULT;
                    end else if (i_stat.at_last) begin
                        o_cmd.rem_fin    = 1'b1;
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = rqr_pkg::ST_DONE;
                        n_state          = S_RESULT;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (i_stat.at_last) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = rqr_pkg::ST_MISS;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.shift_last) begin
                    o_cmd.rem_fin    = 1'b1;
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = rqr_pkg::ST_DONE;
                    n_state          = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // an accepted transaction is decoded in the next cycle
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EXEC))
        else $error("accepted transaction not decoded");

    // no enqueue into a full queue
    a_enq_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.enq |-> !i_stat.full)
        else $error("enqueue issued while full");

    // removal only finishes on a scan or shift of a remove transaction
    a_rem_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rem_fin |-> (i_stat.act == rqr_pkg::ACT_REMOVE))
        else $error("removal finished for wrong operation");

endmodule

// ===== design/rqr_dpath.sv =====
// datapath for the ready queue with remove: circular entry memory,
// pointers, occupancy, scan position and result registers; depends on rqr_pkg

module rqr_dpath #(
    parameter int DEPTH    = 16,
    parameter int ID_WIDTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rqr_pkg::t_cmd                i_cmd,
    output rqr_pkg::t_stat               o_stat,
    input  logic [rqr_pkg::ACT_W-1:0]    i_action,
    input  logic [rqr_pkg::TID_W-1:0]    i_thread_id,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rqr_pkg::STAT_W-1:0]   o_status,
    output logic [rqr_pkg::TID_W-1:0]    o_out_id,
    output logic                         o_now_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    logic [ID_WIDTH-1:0]          r_mem [DEPTH];
    logic [ID_WIDTH-1:0]          r_rd_data;
    logic [ID_WIDTH-1:0]          r_key;
    logic [rqr_pkg::ACT_W-1:0]    r_act;
    logic [PTR_W-1:0]             r_head;
    logic [PTR_W-1:0]             r_tail;
    logic [OCC_W-1:0]             r_occ;
    logic [PTR_W-1:0]             r_cpos;
    logic [PTR_W-1:0]             r_cnt;
    logic [rqr_pkg::STAT_W-1:0]   r_res_status;
    logic [rqr_pkg::TID_W-1:0]    r_res_id;
    logic                         r_out_valid;
    logic [rqr_pkg::STAT_W-1:0]   r_out_status;
    logic [rqr_pkg::TID_W-1:0]    r_out_id;
    logic                         r_out_empty;

    logic [ID_WIDTH-1:0]          w_key;
    logic [rqr_pkg::TID_W-1:0]    w_rd_id;
    logic [PTR_W-1:0]             w_nxt1;
    logic [PTR_W-1:0]             w_nxt2;
    logic [PTR_W-1:0]             w_head_nxt;
    logic [PTR_W-1:0]             w_tail_nxt;
    logic [PTR_W-1:0]             w_tail_prv;
    logic                         w_rd_en;
    logic [PTR_W-1:0]             w_rd_addr;
    logic                         w_wr_en;
    logic [PTR_W-1:0]             w_wr_addr;
    logic [ID_WIDTH-1:0]          w_wr_data;
    logic                         w_out_free;

    // identifier sizing between the 8-bit ports and the stored width
    generate
        if (ID_WIDTH > rqr_pkg::TID_W) begin : g_wide
            assign w_key   = {{(ID_WIDTH - rqr_pkg::TID_W){1'b0}}, i_thread_id};
            assign w_rd_id = r_rd_data[rqr_pkg::TID_W-1:0];
        end else if (ID_WIDTH == rqr_pkg::TID_W) begin : g_same
            assign w_key   = i_thread_id;
            assign w_rd_id = r_rd_data;
        end else begin : g_narrow
            assign w_key   = i_thread_id[ID_WIDTH-1:0];
            assign w_rd_id = {{(rqr_pkg::TID_W - ID_WIDTH){1'b0}}, r_rd_data};
        end
    endgenerate

    // circular pointer arithmetic
    always_comb begin
        w_nxt1     = (r_cpos == PTR_W'(DEPTH - 1)) ? '0 : r_cpos + PTR_W'(1);
        w_nxt2     = (w_nxt1 == PTR_W'(DEPTH - 1)) ? '0 : w_nxt1 + PTR_W'(1);
        w_head_nxt = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
        w_tail_nxt = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
        w_tail_prv = (r_tail == '0) ? PTR_W'(DEPTH - 1) : r_tail - PTR_W'(1);
    end

    // memory port selection
    always_comb begin
        w_rd_en   = i_cmd.deq_rd | i_cmd.scan_start | i_cmd.scan_read | i_cmd.shift_step;
        priority if (i_cmd.deq_rd || i_cmd.scan_start) begin
            w_rd_addr = r_head;
        end else if (i_cmd.scan_read) begin
            w_rd_addr = w_nxt1;
        end else begin
            w_rd_addr = w_nxt2;
        end
        w_wr_en   = i_cmd.enq | i_cmd.shift_step;
        w_wr_addr = i_cmd.enq ? r_tail : r_cpos;
        w_wr_data = i_cmd.enq ? r_key : r_rd_data;
    end

    // entry memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // transaction capture and scan position
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_key <= w_key;
        end
        if (i_cmd.scan_start) begin
            r_cpos <= r_head;
            r_cnt  <= '0;
        end else if (i_cmd.scan_adv || i_cmd.shift_step) begin
            r_cpos <= w_nxt1;
            r_cnt  <= r_cnt + PTR_W'(1);
        end
    end

    // queue pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else begin
            if (i_cmd.enq) begin
                r_tail <= w_tail_nxt;
                r_occ  <= r_occ + OCC_W'(1);
            end else if (i_cmd.deq_fin) begin
                r_head <= w_head_nxt;
                r_occ  <= r_occ - OCC_W'(1);
            end else if (i_cmd.rem_fin) begin
                r_tail <= w_tail_prv;
                r_occ  <= r_occ - OCC_W'(1);
            end
        end
    end

    // result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            r_res_id     <= i_cmd.deq_fin ? w_rd_id : '0;
        end
    end

    // output register
    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_empty  <= (r_occ == '0);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_id    = r_out_id;
    assign o_now_empty = r_out_empty;

    // status towards the controller
    always_comb begin
        o_stat.act        = r_act;
        o_stat.full       = (r_occ == OCC_W'(DEPTH));
        o_stat.empty      = (r_occ == '0);
        o_stat.match      = (r_rd_data == r_key);
        o_stat.at_last    = (OCC_W'(r_cnt) == r_occ - OCC_W'(1));
        o_stat.shift_last = (OCC_W'(r_cnt) + OCC_W'(2) == r_occ);
        o_stat.out_free   = w_out_free;
    end

    // occupancy stays within capacity
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(DEPTH))
        else $error("occupancy beyond capacity");

    // pointers meet when the queue is empty or full
    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0 || r_occ == OCC_W'(DEPTH)) |-> (r_head == r_tail))
        else $error("head and tail disagree with occupancy");

    // a result is never pushed over one still waiting
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> w_out_free)
        else $error("result pushed over pending output");

endmodule

// ===== design/ready_queue_with_remove.sv =====
// top level of the ready queue with remove
// depends on rqr_pkg, rqr_ctrl and rqr_dpath

// Bounded first-in first-out queue of DEPTH thread identifiers with
// enqueue, dequeue, presence test and order-keeping removal of the oldest
// matching entry. Entries sit in a circular memory with one write and one
// registered read a cycle, which sets the timing. A transaction is taken
// only while the controller is idle. After acceptance the controller
// decodes it. An enqueue, a refused enqueue or an operation on an empty
// queue then stages its result; a dequeue first reads the head entry;
// a test or removal scans from the head until it hits or reaches the
// youngest entry, and a removal that hits then moves every younger entry
// forward one place a cycle. The staged result enters the output register
// once that register is free, and the controller is idle again from that
// same edge, so a new transaction is accepted only after the result of
// the last one has reached the output register. The output register
// holds a result until taken while the next transaction is accepted and
// worked on; a result only waits in the controller when the one before
// is still held. Thread identifiers wider than ID_WIDTH lose their high
// bits; a dequeued identifier is returned in its low 8 bits.

module ready_queue_with_remove #(
    parameter int DEPTH    = 16,
    parameter int ID_WIDTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rqr_pkg::ACT_W-1:0]    i_action,
    input  logic [rqr_pkg::TID_W-1:0]    i_thread_id,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rqr_pkg::STAT_W-1:0]   o_status,
    output logic [rqr_pkg::TID_W-1:0]    o_out_id,
    output logic                         o_now_empty
);

    rqr_pkg::t_cmd  w_cmd;
    rqr_pkg::t_stat w_stat;

    // sequencing of each transaction
    rqr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // storage, pointers and result registers
    rqr_dpath #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_action    (i_action),
        .i_thread_id (i_thread_id),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_out_id    (o_out_id),
        .o_now_empty (o_now_empty)
    );

endmodule
